[design/assert_macros.svh]
// Assertion macros shared by the heading and pursuit step design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed: property violated");

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle property violated");

`endif

[design/hps_pkg.sv]
// Package with constants, types and the arctangent table of the pursuit step.
`timescale 1ns / 1ps
package hps_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_DEPTH   = 24;
   localparam int ATAN_IDX_W   = $clog2(ATAN_DEPTH);

   localparam int POS_W     = 24;
   localparam int HEAD_W    = 15;
   localparam int DT_W      = 16;
   localparam int DIFF_W    = POS_W + 1;
   localparam int CX_W      = POS_W + 4;
   localparam int Z_W       = 26;
   localparam int MUL_W     = 25;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int DIV_NUM_W = 43;
   localparam int DIV_DEN_W = 25;
   localparam int ROOT_W    = 25;
   localparam int RAD_W     = 2 * ROOT_W;
   localparam int TURN_W    = 13;
   localparam int STEP_W    = 17;

   // rate scaling: floor((x + 7812) / 15625) as a reciprocal multiply, x below 2**30
   localparam int SCALED_W     = 30;
   localparam int RECIP_W      = 31;
   localparam int RECIP_SHIFT  = 44;
   localparam int RECIP_PROD_W = SCALED_W + RECIP_W;
   localparam logic [RECIP_W-1:0]  RECIP_MUL  = 31'd1125899907;
   localparam logic [SCALED_W-1:0] RATE_ROUND = 30'd7812;

   localparam int FULL_TURN  = 23040;
   localparam int HALF_TURN  = 11520;
   localparam int Z_HALF     = 180 * 65536;
   localparam int Z_ROUND    = 512;
   localparam int MICRO      = 1000000;
   localparam int MICRO_HALF = 500000;
   localparam int POS_MAX    = 8388607;
   localparam int POS_MIN    = -8388608;

   localparam int POS_X_RESET      = 102400;
   localparam int POS_Y_RESET      = 76800;
   localparam int TURN_RATE_RESET  = 90;
   localparam int MOVE_SPEED_RESET = 20;
   localparam int SNAP_TOL_RESET   = 32;
   localparam int MIN_DIST_RESET   = 128;

   localparam logic [7:0] CSR_TURN_RATE  = 8'd0;
   localparam logic [7:0] CSR_MOVE_SPEED = 8'd1;
   localparam logic [7:0] CSR_SNAP_TOL   = 8'd2;
   localparam logic [7:0] CSR_MIN_DIST   = 8'd3;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_DIFF,
      OP_MUL_DX,
      OP_MUL_DY,
      OP_MUL_MIN,
      OP_MUL_TURN,
      OP_TURN_SAVE,
      OP_MUL_MOVE,
      OP_STEP_SAVE,
      OP_SQRT_GO,
      OP_DIST_SAVE,
      OP_CORDIC_INIT,
      OP_CORDIC_ITER,
      OP_BEARING,
      OP_HEADING,
      OP_MUL_AX,
      OP_DIV_AX_GO,
      OP_POS_X_SAVE,
      OP_MUL_AY,
      OP_DIV_AY_GO,
      OP_POS_Y_SAVE,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic sqrt_done;
      logic cordic_last;
      logic move_en;
   } stat_type;

   function automatic logic signed [Z_W-1:0] atan_z(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [Z_W-1:0] v;
      case (idx)
         5'd0:    v = 26'sd2949120;
         5'd1:    v = 26'sd1740967;
         5'd2:    v = 26'sd919879;
         5'd3:    v = 26'sd466945;
         5'd4:    v = 26'sd234378;
         5'd5:    v = 26'sd117304;
         5'd6:    v = 26'sd58666;
         5'd7:    v = 26'sd29335;
         5'd8:    v = 26'sd14668;
         5'd9:    v = 26'sd7334;
         5'd10:   v = 26'sd3667;
         5'd11:   v = 26'sd1833;
         5'd12:   v = 26'sd917;
         5'd13:   v = 26'sd458;
         5'd14:   v = 26'sd229;
         5'd15:   v = 26'sd115;
         5'd16:   v = 26'sd57;
         5'd17:   v = 26'sd29;
         5'd18:   v = 26'sd14;
         5'd19:   v = 26'sd7;
         5'd20:   v = 26'sd4;
         5'd21:   v = 26'sd2;
         5'd22:   v = 26'sd1;
         default: v = 26'sd0;
      endcase
      return v;
   endfunction

endpackage

[design/hps_div.sv]
// Bit-serial restoring divider for the axis divisions by the distance.
`timescale 1ns / 1ps
module hps_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [hps_pkg::DIV_NUM_W-1:0]   num,
   input  logic [hps_pkg::DIV_DEN_W-1:0]   den,
   output logic                            done,
   output logic [hps_pkg::DIV_NUM_W-1:0]   quo
);
   import hps_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W);

   logic                 busy_ff, done_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [DIV_DEN_W-1:0] rem_ff, den_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W:0]   trial;
   logic                 ge;

   always_comb begin
      trial  = {rem_ff, quo_ff[DIV_NUM_W-1]};
      ge     = trial >= {1'b0, den_ff};
      rem_in = ge ? DIV_DEN_W'(trial - {1'b0, den_ff}) : trial[DIV_DEN_W-1:0];
      quo_in = {quo_ff[DIV_NUM_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= num;
            den_ff  <= den;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

[design/hps_sqrt.sv]
// Digit-by-digit integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module hps_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [hps_pkg::RAD_W-1:0]    rad,
   output logic                         done,
   output logic [hps_pkg::ROOT_W-1:0]   root
);
   import hps_pkg::*;

   localparam int CNT_W = $clog2(ROOT_W);
   localparam int REM_W = ROOT_W + 2;

   logic               busy_ff, done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [RAD_W-1:0]   rad_ff;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]  root_ff, root_in;
   logic [REM_W+1:0]   rem_sh, trial;
   logic               ge;

   always_comb begin
      rem_sh  = {rem_ff, rad_ff[RAD_W-1:RAD_W-2]};
      trial   = {2'b00, root_ff, 2'b01};
      ge      = rem_sh >= trial;
      rem_in  = ge ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
      root_in = {root_ff[ROOT_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            root_ff <= '0;
            rad_ff  <= rad;
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            root_ff <= root_in;
            rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
            cnt_ff  <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

[design/hps_dp.sv]
// Datapath: registers, shared multiplier, CORDIC, divider and square root.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hps_dp (
   input  logic               clock,
   input  logic               reset,
   input  hps_pkg::cmd_type   cmd,
   output hps_pkg::stat_type  stat,
   input  logic [63:0]        req_tdata,
   input  logic               csr_valid,
   input  logic [7:0]         csr_index,
   input  logic [15:0]        csr_data,
   output logic [63:0]        rsp_tdata
);
   import hps_pkg::*;

   logic [9:0]                turn_rate_ff;
   logic [11:0]               move_speed_ff;
   logic [7:0]                snap_tol_ff;
   logic [15:0]               min_dist_ff;
   logic signed [POS_W-1:0]   pos_x_ff, pos_y_ff, tx_ff, ty_ff, pos_in;
   logic [HEAD_W-1:0]         heading_ff, bear_ff, bear_in, heading_in;
   logic [DT_W-1:0]           dt_ff;
   logic signed [DIFF_W-1:0]  dx_ff, dy_ff, d_sel;
   logic [DIFF_W-1:0]         ax, ay;
   logic [PROD_W-1:0]         prod_ff, d2_ff, mul_in;
   logic [MUL_W-1:0]          mul_a, mul_b;
   logic                      turn_en_ff, move_en_ff;
   logic [TURN_W-1:0]         turn_ff;
   logic [STEP_W-1:0]         step_ff;
   logic [ROOT_W-1:0]         dist_ff, root;
   logic signed [CX_W-1:0]    cx_ff, cy_ff, cx_in, cy_in, xs, ys;
   logic signed [Z_W-1:0]     cz_ff, cz_in, zr, atan_v;
   logic [ATAN_IDX_W-1:0]     iter_ff;
   logic [63:0]               rsp_data_ff;
   logic                      div_start, div_done, sqrt_start, sqrt_done;
   logic [DIV_NUM_W-1:0]      div_num, quo;
   logic [DIV_DEN_W-1:0]      div_den;
   logic signed [16:0]        b_raw, b_mid, b_fin, diff0, adiff, diff1, h0, h1;
   logic                      snap;
   logic signed [POS_W+1:0]   p_sum, delta_s;
   logic signed [POS_W-1:0]   p_sel;
   logic [SCALED_W-1:0]       scaled;
   logic [RECIP_PROD_W-1:0]   recip_prod;

   assign ax = dx_ff[DIFF_W-1] ? DIFF_W'(-dx_ff) : DIFF_W'(dx_ff);
   assign ay = dy_ff[DIFF_W-1] ? DIFF_W'(-dy_ff) : DIFF_W'(dy_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_MUL_DX:   begin mul_a = ax; mul_b = ax; end
         OP_MUL_DY:   begin mul_a = ay; mul_b = ay; end
         OP_MUL_MIN:  begin mul_a = MUL_W'(min_dist_ff); mul_b = MUL_W'(min_dist_ff); end
         OP_MUL_TURN: begin mul_a = MUL_W'(turn_rate_ff); mul_b = MUL_W'(dt_ff); end
         OP_MUL_MOVE: begin mul_a = MUL_W'({move_speed_ff, 2'b0}); mul_b = MUL_W'(dt_ff); end
         OP_MUL_AX:   begin mul_a = MUL_W'(step_ff); mul_b = ax; end
         OP_MUL_AY:   begin mul_a = MUL_W'(step_ff); mul_b = ay; end
         default: ;
      endcase
      mul_in = mul_a * mul_b;
   end

   assign scaled     = prod_ff[SCALED_W-1:0] + RATE_ROUND;
   assign recip_prod = RECIP_PROD_W'(scaled) * RECIP_PROD_W'(RECIP_MUL);

   always_comb begin
      div_start  = (cmd.op == OP_DIV_AX_GO) || (cmd.op == OP_DIV_AY_GO);
      div_num    = prod_ff[DIV_NUM_W-1:0] + DIV_NUM_W'(dist_ff[ROOT_W-1:1]);
      div_den    = dist_ff;
      sqrt_start = cmd.op == OP_SQRT_GO;
   end

   hps_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (quo)
   );

   hps_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .rad   (d2_ff),
      .done  (sqrt_done),
      .root  (root)
   );

   always_comb begin
      xs     = cx_ff >>> iter_ff;
      ys     = cy_ff >>> iter_ff;
      atan_v = atan_z(iter_ff);
      if (cy_ff > 0) begin
         cx_in = cx_ff + ys;
         cy_in = cy_ff - xs;
         cz_in = cz_ff + atan_v;
      end else begin
         cx_in = cx_ff - ys;
         cy_in = cy_ff + xs;
         cz_in = cz_ff - atan_v;
      end
   end

   always_comb begin
      zr      = cz_ff + Z_W'(Z_ROUND);
      b_raw   = 17'(zr >>> 10);
      b_mid   = (b_raw > 17'(FULL_TURN)) ? b_raw - 17'(FULL_TURN) : b_raw;
      b_fin   = (b_mid <= 17'sd0) ? b_mid + 17'(FULL_TURN) : b_mid;
      bear_in = b_fin[HEAD_W-1:0];
   end

   always_comb begin
      diff0 = $signed({2'b00, bear_ff}) - $signed({2'b00, heading_ff});
      adiff = diff0[16] ? -diff0 : diff0;
      snap  = adiff < $signed({9'b0, snap_tol_ff});
      if (adiff > 17'(HALF_TURN)) begin
         diff1 = (diff0 <= 17'sd0) ? diff0 + 17'(FULL_TURN) : diff0 - 17'(FULL_TURN);
      end else begin
         diff1 = diff0;
      end
      if (snap) begin
         h0 = $signed({2'b00, bear_ff});
      end else if (diff1 < 17'sd0) begin
         h0 = $signed({2'b00, heading_ff}) - $signed({4'b0, turn_ff});
      end else begin
         h0 = $signed({2'b00, heading_ff}) + $signed({4'b0, turn_ff});
      end
      if (h0 < 17'sd0) begin
         h1 = h0 + 17'(FULL_TURN);
      end else if (h0 >= 17'(FULL_TURN)) begin
         h1 = h0 - 17'(FULL_TURN);
      end else begin
         h1 = h0;
      end
      heading_in = h1[HEAD_W-1:0];
   end

   always_comb begin
      if (cmd.op == OP_POS_X_SAVE) begin
         d_sel = dx_ff;
         p_sel = pos_x_ff;
      end else begin
         d_sel = dy_ff;
         p_sel = pos_y_ff;
      end
      delta_s = $signed({9'b0, quo[STEP_W-1:0]});
      p_sum   = d_sel[DIFF_W-1] ? (POS_W+2)'(p_sel) - delta_s : (POS_W+2)'(p_sel) + delta_s;
      if (p_sum > (POS_W+2)'(POS_MAX)) begin
         pos_in = POS_W'(POS_MAX);
      end else if (p_sum < (POS_W+2)'(POS_MIN)) begin
         pos_in = POS_W'(POS_MIN);
      end else begin
         pos_in = p_sum[POS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_rate_ff  <= 10'(TURN_RATE_RESET);
         move_speed_ff <= 12'(MOVE_SPEED_RESET);
         snap_tol_ff   <= 8'(SNAP_TOL_RESET);
         min_dist_ff   <= 16'(MIN_DIST_RESET);
         pos_x_ff      <= POS_W'(POS_X_RESET);
         pos_y_ff      <= POS_W'(POS_Y_RESET);
         heading_ff    <= '0;
         turn_en_ff    <= 1'b0;
         move_en_ff    <= 1'b0;
         iter_ff       <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_TURN_RATE:  turn_rate_ff  <= csr_data[9:0];
               CSR_MOVE_SPEED: move_speed_ff <= csr_data[11:0];
               CSR_SNAP_TOL:   snap_tol_ff   <= csr_data[7:0];
               CSR_MIN_DIST:   min_dist_ff   <= csr_data;
               default: ;
            endcase
         end
         case (cmd.op)
            OP_LOAD: begin
               tx_ff <= req_tdata[23:0];
               ty_ff <= req_tdata[47:24];
               dt_ff <= req_tdata[63:48];
            end
            OP_DIFF: begin
               dx_ff <= DIFF_W'(tx_ff) - DIFF_W'(pos_x_ff);
               dy_ff <= DIFF_W'(ty_ff) - DIFF_W'(pos_y_ff);
            end
            OP_MUL_DX:   prod_ff <= mul_in;
            OP_MUL_DY: begin
               d2_ff   <= prod_ff;
               prod_ff <= mul_in;
            end
            OP_MUL_MIN: begin
               d2_ff   <= d2_ff + prod_ff;
               prod_ff <= mul_in;
            end
            OP_MUL_TURN: begin
               turn_en_ff <= d2_ff > prod_ff;
               move_en_ff <= d2_ff != '0;
               prod_ff    <= mul_in;
            end
            OP_TURN_SAVE: turn_ff <= recip_prod[RECIP_SHIFT +: TURN_W];
            OP_MUL_MOVE:  prod_ff <= mul_in;
            OP_STEP_SAVE: step_ff <= recip_prod[RECIP_SHIFT +: STEP_W];
            OP_DIST_SAVE: dist_ff <= root;
            OP_CORDIC_INIT: begin
               iter_ff <= '0;
               if (dx_ff[DIFF_W-1]) begin
                  cx_ff <= -CX_W'(dx_ff);
                  cy_ff <= -CX_W'(dy_ff);
                  cz_ff <= Z_W'(Z_HALF);
               end else begin
                  cx_ff <= CX_W'(dx_ff);
                  cy_ff <= CX_W'(dy_ff);
                  cz_ff <= '0;
               end
            end
            OP_CORDIC_ITER: begin
               cx_ff   <= cx_in;
               cy_ff   <= cy_in;
               cz_ff   <= cz_in;
               iter_ff <= iter_ff + 1'b1;
            end
            OP_BEARING: bear_ff <= bear_in;
            OP_HEADING: begin
               if (turn_en_ff) begin
                  heading_ff <= heading_in;
               end
            end
            OP_MUL_AX:     prod_ff  <= mul_in;
            OP_POS_X_SAVE: pos_x_ff <= pos_in;
            OP_MUL_AY:     prod_ff  <= mul_in;
            OP_POS_Y_SAVE: pos_y_ff <= pos_in;
            OP_EMIT:       rsp_data_ff <= {1'b0, heading_ff, pos_y_ff, pos_x_ff};
            default: ;
         endcase
      end
   end

   assign stat.div_done    = div_done;
   assign stat.sqrt_done   = sqrt_done;
   assign stat.cordic_last = iter_ff == ATAN_IDX_W'(CORDIC_STEPS - 1);
   assign stat.move_en     = move_en_ff;
   assign rsp_tdata        = rsp_data_ff;

   `ASSERT_NEXT(a_heading_wrapped, clock, reset, cmd.op == OP_HEADING, heading_ff < 15'(FULL_TURN))
   `ASSERT_NEXT(a_cordic_start, clock, reset, cmd.op == OP_CORDIC_INIT, iter_ff == '0)

endmodule

[design/hps_ctrl.sv]
// Controller: sequences one transaction through the datapath operations.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hps_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  hps_pkg::stat_type  stat,
   output hps_pkg::cmd_type   cmd,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready
);
   import hps_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_DIFF, S_MUL_DX, S_MUL_DY, S_MUL_MIN, S_MUL_TURN,
      S_SAVE_TURN, S_MUL_MOVE, S_SAVE_STEP, S_SQRT, S_WAIT_SQRT, S_SAVE_DIST,
      S_CORDIC_INIT, S_CORDIC, S_BEARING, S_HEADING, S_MUL_AX, S_DIV_AX, S_WAIT_AX,
      S_SAVE_AX, S_MUL_AY, S_DIV_AY, S_WAIT_AY, S_SAVE_AY, S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in, emit_go;
   logic      div_wait;

   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      emit_go  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DIFF;
            end
         end
         S_DIFF:      begin cmd.op = OP_DIFF;        state_in = S_MUL_DX;    end
         S_MUL_DX:    begin cmd.op = OP_MUL_DX;      state_in = S_MUL_DY;    end
         S_MUL_DY:    begin cmd.op = OP_MUL_DY;      state_in = S_MUL_MIN;   end
         S_MUL_MIN:   begin cmd.op = OP_MUL_MIN;     state_in = S_MUL_TURN;  end
         S_MUL_TURN:  begin cmd.op = OP_MUL_TURN;    state_in = S_SAVE_TURN; end
         S_SAVE_TURN: begin cmd.op = OP_TURN_SAVE;   state_in = S_MUL_MOVE;  end
         S_MUL_MOVE:  begin cmd.op = OP_MUL_MOVE;    state_in = S_SAVE_STEP; end
         S_SAVE_STEP: begin cmd.op = OP_STEP_SAVE;   state_in = S_SQRT;      end
         S_SQRT:      begin cmd.op = OP_SQRT_GO;     state_in = S_WAIT_SQRT; end
         S_WAIT_SQRT: if (stat.sqrt_done) state_in = S_SAVE_DIST;
         S_SAVE_DIST: begin cmd.op = OP_DIST_SAVE;   state_in = S_CORDIC_INIT; end
         S_CORDIC_INIT: begin cmd.op = OP_CORDIC_INIT; state_in = S_CORDIC;  end
         S_CORDIC: begin
            cmd.op = OP_CORDIC_ITER;
            if (stat.cordic_last) state_in = S_BEARING;
         end
         S_BEARING:   begin cmd.op = OP_BEARING;     state_in = S_HEADING;   end
         S_HEADING: begin
            cmd.op   = OP_HEADING;
            state_in = stat.move_en ? S_MUL_AX : S_EMIT;
         end
         S_MUL_AX:    begin cmd.op = OP_MUL_AX;      state_in = S_DIV_AX;    end
         S_DIV_AX:    begin cmd.op = OP_DIV_AX_GO;   state_in = S_WAIT_AX;   end
         S_WAIT_AX:   if (stat.div_done) state_in = S_SAVE_AX;
         S_SAVE_AX:   begin cmd.op = OP_POS_X_SAVE;  state_in = S_MUL_AY;    end
         S_MUL_AY:    begin cmd.op = OP_MUL_AY;      state_in = S_DIV_AY;    end
         S_DIV_AY:    begin cmd.op = OP_DIV_AY_GO;   state_in = S_WAIT_AY;   end
         S_WAIT_AY:   if (stat.div_done) state_in = S_SAVE_AY;
         S_SAVE_AY:   begin cmd.op = OP_POS_Y_SAVE;  state_in = S_EMIT;      end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op   = OP_EMIT;
               emit_go  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = (rsp_valid_ff && !rsp_tready) || emit_go;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign div_wait   = (state_ff == S_WAIT_AX) || (state_ff == S_WAIT_AY);

   `ASSERT_CLK(a_div_done_waits, clock, reset, stat.div_done |-> div_wait)
   `ASSERT_CLK(a_sqrt_done_waits, clock, reset, stat.sqrt_done |-> state_ff == S_WAIT_SQRT)
   `ASSERT_CLK(a_rsp_from_emit, clock, reset, $rose(rsp_tvalid) |-> $past(state_ff == S_EMIT))

endmodule

[design/heading_and_pursuit_step.sv]
// Top level of the slew-rate-limited pursuit steering step.
// One transaction in flight; a new request is taken only when the last one is done.
// Transaction time is set by two bit-serial divisions by the distance (only when the
// object moves), a square root and CORDIC_STEPS iterations; a result not yet taken
// stalls the next one. Synchronous reset: position (400, 300) pixels, heading zero,
// registers at defaults.
`timescale 1ns / 1ps
module heading_and_pursuit_step (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // target_x[23:0], target_y[47:24], time_step_us[63:48]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // position_x_out[23:0], position_y_out[47:24],
                                    // heading_out[62:48], zero[63]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);
   import hps_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   hps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .stat       (stat),
      .cmd        (cmd),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   hps_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tdata (req_tdata),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata)
   );

endmodule

[tb/tb_top.sv]
// Self-checking bench for the pursuit step: directed and random target ticks with a predicted trajectory.
`timescale 1ns / 1ps
module tb_top;
   import hps_pkg::*;

   class pursuit_scoreboard;
      typedef struct {
         logic [23:0] pos_x;
         logic [23:0] pos_y;
         logic [14:0] heading;
      } pose_type;

      longint   turn_rate, move_speed, snap_tol, min_dist;
      longint   pos_x, pos_y, heading;
      pose_type pending_poses[$];
      int       errors;
      longint atan_tab[24] = '{2949120, 1740967, 919879, 466945, 234378, 117304, 58666,
                               29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                               57, 29, 14, 7, 4, 2, 1, 0};

      function new();
         turn_rate  = TURN_RATE_RESET;
         move_speed = MOVE_SPEED_RESET;
         snap_tol   = SNAP_TOL_RESET;
         min_dist   = MIN_DIST_RESET;
         pos_x      = POS_X_RESET;
         pos_y      = POS_Y_RESET;
         heading    = 0;
         errors     = 0;
      endfunction

      function void write_reg(logic [7:0] idx, logic [15:0] val);
         case (idx)
            CSR_TURN_RATE:  turn_rate  = val[9:0];
            CSR_MOVE_SPEED: move_speed = val[11:0];
            CSR_SNAP_TOL:   snap_tol   = val[7:0];
            CSR_MIN_DIST:   min_dist   = val[15:0];
            default: ;
         endcase
      endfunction

      function longint int_sqrt(longint n);
         longint root, bits;
         root = 0;
         bits = 64'sd1 <<< 62;
         while (bits > n) bits = bits >>> 2;
         while (bits != 0) begin
            if (n >= root + bits) begin
               n    = n - (root + bits);
               root = (root >>> 1) + bits;
            end else begin
               root = root >>> 1;
            end
            bits = bits >>> 2;
         end
         return root;
      endfunction

      function longint target_bearing(longint dx, longint dy);
         longint x, y, z, xs, ys, b;
         x = dx;
         y = dy;
         z = 0;
         if (x < 0) begin
            x = -x;
            y = -y;
            z = 180 * 65536;
         end
         for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
               x = x + ys;
               y = y - xs;
               z = z + atan_tab[i];
            end else begin
               x = x - ys;
               y = y + xs;
               z = z - atan_tab[i];
            end
         end
         b = (z + 512) >>> 10;
         if (b > FULL_TURN) b = b - FULL_TURN;
         if (b <= 0) b = b + FULL_TURN;
         return b;
      endfunction

      function longint advance_axis(longint p, longint step, longint d, longint radius);
         longint mag, delta;
         mag   = d < 0 ? -d : d;
         delta = (step * mag + radius / 2) / radius;
         p     = d < 0 ? p - delta : p + delta;
         if (p > POS_MAX) p = POS_MAX;
         if (p < POS_MIN) p = POS_MIN;
         return p;
      endfunction

      function void note_request(logic [23:0] tx_b, logic [23:0] ty_b, logic [15:0] dt_b);
         longint   dx, dy, d2, b, diff, adiff, h, turn, radius, step, dt;
         pose_type pose;
         dt = dt_b;
         dx = longint'($signed(tx_b)) - pos_x;
         dy = longint'($signed(ty_b)) - pos_y;
         d2 = dx * dx + dy * dy;
         if (d2 > min_dist * min_dist) begin
            b     = target_bearing(dx, dy);
            diff  = b - heading;
            adiff = diff < 0 ? -diff : diff;
            if (adiff < snap_tol) begin
               h = b;
            end else begin
               turn = (turn_rate * 64 * dt + MICRO_HALF) / MICRO;
               if (adiff > HALF_TURN) diff = diff <= 0 ? diff + FULL_TURN : diff - FULL_TURN;
               h = heading + (diff < 0 ? -turn : turn);
            end
            while (h < 0) h = h + FULL_TURN;
            while (h >= FULL_TURN) h = h - FULL_TURN;
            heading = h;
         end
         if (d2 > 0) begin
            radius = int_sqrt(d2);
            step   = (move_speed * 256 * dt + MICRO_HALF) / MICRO;
            pos_x  = advance_axis(pos_x, step, dx, radius);
            pos_y  = advance_axis(pos_y, step, dy, radius);
         end
         pose.pos_x   = pos_x[23:0];
         pose.pos_y   = pos_y[23:0];
         pose.heading = heading[14:0];
         pending_poses.push_back(pose);
      endfunction

      function void check_result(logic [63:0] data);
         pose_type want;
         if (pending_poses.size() == 0) begin
            $error("unexpected result %h", data);
            errors++;
            return;
         end
         want = pending_poses.pop_front();
         if (data[23:0] !== want.pos_x) begin
            $error("position_x_out: expected %0d, got %0d",
                   $signed(want.pos_x), $signed(data[23:0]));
            errors++;
         end
         if (data[47:24] !== want.pos_y) begin
            $error("position_y_out: expected %0d, got %0d",
                   $signed(want.pos_y), $signed(data[47:24]));
            errors++;
         end
         if (data[62:48] !== want.heading) begin
            $error("heading_out: expected %0d, got %0d", want.heading, data[62:48]);
            errors++;
         end
      endfunction
   endclass

   localparam int SETTLE_CYCLES = 300;
   localparam int STALL_LIMIT   = 20000;
   localparam int NUM_PHASES    = 8;
   localparam int PHASE_ITEMS   = 222;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   pursuit_scoreboard tracker = new();
   bit steady = 1'b0;
   int stall_cycles = 0;

   heading_and_pursuit_step i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 28);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_result(rsp_tdata);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready)
          || reset)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_tick(logic [23:0] tx, logic [23:0] ty, logic [15:0] dt);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 28) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {dt, ty, tx};
      do @(posedge clock); while (!req_tready);
      tracker.note_request(tx, ty, dt);
   endtask

   task automatic write_csr(logic [7:0] idx, logic [15:0] val);
      @(negedge clock);
      req_tvalid = 1'b0;
      csr_valid  = 1'b1;
      csr_index  = idx;
      csr_data   = val;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (tracker.pending_poses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_tick();
      logic [23:0] tx, ty;
      logic [15:0] dt;
      int          pick, span;
      pick = $urandom_range(99);
      span = 1 << $urandom_range(18, 4);
      if (pick < 60) begin
         tx = 24'(tracker.pos_x + $signed($urandom_range(2 * span) - span));
         ty = 24'(tracker.pos_y + $signed($urandom_range(2 * span) - span));
      end else if (pick < 70) begin
         tx = tracker.pos_x[23:0];
         ty = tracker.pos_y[23:0];
      end else begin
         tx = 24'($urandom);
         ty = 24'($urandom);
      end
      dt = ($urandom_range(99) < 70) ? 16'($urandom_range(17000, 16000)) : 16'($urandom);
      send_tick(tx, ty, dt);
   endtask

   initial begin
      logic [15:0] cfg [4];
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: cfg = '{16'd90, 16'd20, 16'd32, 16'd128};
            1: cfg = '{16'd0, 16'd0, 16'd0, 16'd0};
            2: cfg = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
            3: cfg = '{16'd1023, 16'd200, 16'd0, 16'd0};
            default: cfg = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
         endcase
         write_csr(CSR_TURN_RATE, cfg[0]);
         write_csr(CSR_MOVE_SPEED, cfg[1]);
         write_csr(CSR_SNAP_TOL, cfg[2]);
         write_csr(CSR_MIN_DIST, cfg[3]);
         if (phase == 0) write_csr(8'hFF, 16'hFFFF);
         steady = (phase == 3);

         if (phase == 0 || phase == 1) begin
            send_tick(tracker.pos_x[23:0], tracker.pos_y[23:0], 16'd16667);
            send_tick(24'd0, tracker.pos_y[23:0], 16'd0);
            send_tick(24'h7FFFFF, tracker.pos_y[23:0], 16'hFFFF);
            send_tick(tracker.pos_x[23:0], 24'h7FFFFF, 16'd16667);
            send_tick(tracker.pos_x[23:0], 24'h800000, 16'd33333);
            send_tick(24'h800000, 24'h800000, 16'hFFFF);
            send_tick(24'h7FFFFF, 24'h7FFFFF, 16'd1);
            send_tick(24'h800000, 24'h7FFFFF, 16'hAAAA);
            send_tick(tracker.pos_x[23:0] - 24'd1000, tracker.pos_y[23:0], 16'h5555);
            send_tick(tracker.pos_x[23:0] + 24'd3, tracker.pos_y[23:0] + 24'd4, 16'd500);
         end
         if (phase == 2) begin
            repeat (8) send_tick(24'h7FFFFF, 24'h7FFFFF, 16'hFFFF);
            repeat (8) send_tick(24'h800000, 24'h800000, 16'hFFFF);
         end

         for (int n = 0; n < PHASE_ITEMS; n++) random_tick();
         drain();
      end

      if (tracker.errors == 0 && tracker.pending_poses.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
